[design/tsum_pkg.sv]
// ----------------------------------------------------------------------------
// tsum_pkg
// Shared types, constants and helpers for the keep-one-axis tensor sum block.
// ----------------------------------------------------------------------------
package tsum_pkg;

  localparam int SUM_BINS_DEF = 64;
  localparam int DIM_W        = 16;
  localparam int VAL_W        = 32;
  localparam int ACC_W        = 64;
  localparam int IDX_W        = 6;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int AXIS_W       = 2;
  localparam int NUM_DIMS     = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_DIM0 = 3'd0,
    REG_SIZE_DIM1 = 3'd1,
    REG_SIZE_DIM2 = 3'd2,
    REG_SIZE_DIM3 = 3'd3,
    REG_KEPT_AXIS = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_RUN,
    S_FLUSH,
    S_EMIT_RD,
    S_EMIT_OUT
  } state_t;

  typedef struct packed {
    logic [NUM_DIMS-1:0][DIM_W-1:0] size;
    logic [AXIS_W-1:0]              kept;
  } cfg_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;    // input transfer this cycle
    logic emit_rd;   // read accumulator at emit pointer
    logic next_bin;  // advance emit pointer
    logic clear;     // drop all bins, rewind emit pointer
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic wrap;      // current element is the last of the tensor
    logic last_bin;  // emit pointer is on the final bin
  } sts_t;

  // A size of zero behaves as a size of one.
  function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] s);
    eff_size = (s == '0) ? DIM_W'(1) : s;
  endfunction

endpackage

[design/tsum_in_if.sv]
// ----------------------------------------------------------------------------
// tsum_in_if
// Element stream channel: valid/ready with one signed Q16.16 value.
// ----------------------------------------------------------------------------
interface tsum_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [tsum_pkg::VAL_W-1:0]      value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

[design/tsum_out_if.sv]
// ----------------------------------------------------------------------------
// tsum_out_if
// Result channel: valid/ready with bin index, saturated sum and last flag.
// ----------------------------------------------------------------------------
interface tsum_out_if;
  logic                                   valid;
  logic                                   ready;
  logic        [tsum_pkg::IDX_W-1:0]      bin_index;
  logic signed [tsum_pkg::ACC_W-1:0]      bin_sum;
  logic                                   last_bin;

  modport source (output valid, output bin_index, output bin_sum, output last_bin,
                  input ready);
  modport sink   (input valid, input bin_index, input bin_sum, input last_bin,
                  output ready);
endinterface

[design/tsum_ctrl.sv]
// ----------------------------------------------------------------------------
// tsum_ctrl
// Sequencer: stream elements, flush the last add, then emit one sum per bin.
// ----------------------------------------------------------------------------
module tsum_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  tsum_pkg::sts_t      sts,
  output tsum_pkg::cmd_t      cmd
);

  tsum_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsum_pkg::S_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tsum_pkg::S_RUN: begin
        if (in_valid && sts.wrap) begin
          state_nxt = tsum_pkg::S_FLUSH;
        end
      end
      tsum_pkg::S_FLUSH:   state_nxt = tsum_pkg::S_EMIT_RD;
      tsum_pkg::S_EMIT_RD: state_nxt = tsum_pkg::S_EMIT_OUT;
      tsum_pkg::S_EMIT_OUT: begin
        if (out_ready) begin
          state_nxt = sts.last_bin ? tsum_pkg::S_RUN : tsum_pkg::S_EMIT_RD;
        end
      end
      default: state_nxt = tsum_pkg::S_RUN;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    cmd          = '0;
    case (state_r)
      tsum_pkg::S_RUN: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      tsum_pkg::S_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
      end
      tsum_pkg::S_EMIT_OUT: begin
        out_valid    = 1'b1;
        cmd.next_bin = out_ready && !sts.last_bin;
        cmd.clear    = out_ready && sts.last_bin;
      end
      default: ;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and result channels open together");

  a_last_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && sts.wrap) |=> !in_ready)
    else $error("input taken after the final element");

  a_flush_then_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tsum_pkg::S_FLUSH) |=> cmd.emit_rd)
    else $error("emission did not start after flush");

endmodule

[design/tsum_dpath.sv]
// ----------------------------------------------------------------------------
// tsum_dpath
// Position counters, accumulator RAM with forwarded read-add-write, emit read.
// ----------------------------------------------------------------------------
module tsum_dpath #(
  parameter int SUM_BINS = tsum_pkg::SUM_BINS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tsum_pkg::cfg_t                      cfg,
  input  tsum_pkg::cmd_t                      cmd,
  output tsum_pkg::sts_t                      sts,
  input  logic signed [tsum_pkg::VAL_W-1:0]   in_value,
  output logic        [tsum_pkg::IDX_W-1:0]   out_bin_index,
  output logic signed [tsum_pkg::ACC_W-1:0]   out_bin_sum
);

  localparam int ADDR_W = (SUM_BINS > 1) ? $clog2(SUM_BINS) : 1;
  localparam int DIM_W  = tsum_pkg::DIM_W;
  localparam int ACC_W  = tsum_pkg::ACC_W;
  localparam int VAL_W  = tsum_pkg::VAL_W;
  localparam int ND     = tsum_pkg::NUM_DIMS;

  logic [ND-1:0][DIM_W-1:0] cnt_r, cnt_nxt;
  logic [ND-1:0][DIM_W-1:0] eff;
  logic                     carry;

  logic [ACC_W-1:0]         mem [SUM_BINS];
  logic [SUM_BINS-1:0]      vld_r;

  logic [DIM_W-1:0]         bin;
  logic                     bin_hit;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     rd_en;
  logic [ACC_W-1:0]         rd_data_r;
  logic                     rd_vld_r;

  logic                     s1_vld_r;
  logic                     s1_hit_r;
  logic [ADDR_W-1:0]        s1_addr_r;
  logic signed [VAL_W-1:0]  s1_val_r;

  logic                     fw_vld_r;
  logic [ADDR_W-1:0]        fw_addr_r;
  logic [ACC_W-1:0]         fw_data_r;

  logic [ACC_W-1:0]         old_sum;
  logic [ACC_W:0]           sum_wide;
  logic [ACC_W-1:0]         sum_sat;
  logic                     wr_en;

  logic [ADDR_W-1:0]        idx_r;
  logic [DIM_W-1:0]         ksize;
  logic [DIM_W-1:0]         emit_cnt;

  // Row-major position counters, innermost dimension carries outward.
  always_comb begin
    cnt_nxt = cnt_r;
    carry   = 1'b1;
    for (int d = ND - 1; d >= 0; d--) begin
      eff[d] = tsum_pkg::eff_size(cfg.size[d]);
      if (carry) begin
        if (({1'b0, cnt_r[d]} + 17'd1) >= {1'b0, eff[d]}) begin
          cnt_nxt[d] = '0;
        end else begin
          cnt_nxt[d] = cnt_r[d] + DIM_W'(1);
          carry      = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.accept) begin
      cnt_r <= cnt_nxt;
    end
  end

  assign bin     = cnt_r[cfg.kept];
  assign bin_hit = (bin < DIM_W'(SUM_BINS));
  assign rd_en   = cmd.accept || cmd.emit_rd;
  assign rd_addr = cmd.emit_rd ? idx_r : bin[ADDR_W-1:0];

  // Stage 1: add into the bin read at accept time.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      fw_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.accept;
      fw_vld_r <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    s1_hit_r  <= bin_hit;
    s1_addr_r <= bin[ADDR_W-1:0];
    s1_val_r  <= in_value;
    fw_addr_r <= s1_addr_r;
    fw_data_r <= sum_sat;
  end

  // Forward the write of the previous cycle; the RAM read missed it.
  always_comb begin
    if (fw_vld_r && (fw_addr_r == s1_addr_r)) begin
      old_sum = fw_data_r;
    end else if (rd_vld_r) begin
      old_sum = rd_data_r;
    end else begin
      old_sum = '0;
    end
    sum_wide = {old_sum[ACC_W-1], old_sum}
             + {{(ACC_W - VAL_W + 1){s1_val_r[VAL_W-1]}}, s1_val_r};
    if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
      sum_sat = sum_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[ACC_W-1:0];
    end
  end

  assign wr_en = s1_vld_r && s1_hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_addr_r] <= sum_sat;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Entry valid bits stand in for a clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
      if (cmd.clear) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[s1_addr_r] <= 1'b1;
      end
    end
  end

  // Emit pointer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.clear) begin
      idx_r <= '0;
    end else if (cmd.next_bin) begin
      idx_r <= idx_r + ADDR_W'(1);
    end
  end

  assign ksize    = eff[cfg.kept];
  assign emit_cnt = (ksize < DIM_W'(SUM_BINS)) ? ksize : DIM_W'(SUM_BINS);

  assign sts.wrap     = carry;
  assign sts.last_bin = ((DIM_W'(idx_r) + DIM_W'(1)) == emit_cnt);

  assign out_bin_index = tsum_pkg::IDX_W'(idx_r);
  assign out_bin_sum   = rd_vld_r ? rd_data_r : '0;

  a_no_add_at_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> !s1_vld_r)
    else $error("bins cleared with an add in flight");

  a_emit_after_add: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_rd |-> (!s1_vld_r && !cmd.accept))
    else $error("emit read collides with accumulation");

  a_cleared_bins: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (vld_r == '0))
    else $error("valid bits survived clear");

endmodule

[design/tensor_sum_keep_one_axis.sv]
// ----------------------------------------------------------------------------
// tensor_sum_keep_one_axis
// Streaming 4-D tensor sum that keeps one axis, saturating Q48.16 bins.
// ----------------------------------------------------------------------------
// Throughput: one element per cycle; the accumulator RAM read-add-write is
//   split over two stages with the previous write forwarded.
// After the final element: a flush state, then per sum a RAM read state and an
//   output state that holds the sum until transferred; input resumes after the last sum.
// Reset (synchronous, rst_n low): sizes 1, kept axis 0, counters and all bin
//   valid bits zero together, so no clearing pass follows.
// ----------------------------------------------------------------------------
module tensor_sum_keep_one_axis #(
  parameter int SUM_BINS = tsum_pkg::SUM_BINS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  tsum_in_if.sink                              in_ch,
  tsum_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [tsum_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tsum_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  tsum_pkg::cfg_t cfg_r;
  tsum_pkg::cmd_t cmd;
  tsum_pkg::sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.size[0] <= tsum_pkg::DIM_W'(1);
      cfg_r.size[1] <= tsum_pkg::DIM_W'(1);
      cfg_r.size[2] <= tsum_pkg::DIM_W'(1);
      cfg_r.size[3] <= tsum_pkg::DIM_W'(1);
      cfg_r.kept    <= '0;
    end else if (cfg_we) begin
      case (tsum_pkg::cfg_reg_t'(cfg_index))
        tsum_pkg::REG_SIZE_DIM0: cfg_r.size[0] <= cfg_wdata;
        tsum_pkg::REG_SIZE_DIM1: cfg_r.size[1] <= cfg_wdata;
        tsum_pkg::REG_SIZE_DIM2: cfg_r.size[2] <= cfg_wdata;
        tsum_pkg::REG_SIZE_DIM3: cfg_r.size[3] <= cfg_wdata;
        tsum_pkg::REG_KEPT_AXIS: cfg_r.kept    <= cfg_wdata[tsum_pkg::AXIS_W-1:0];
        default: ;
      endcase
    end
  end

  tsum_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tsum_dpath #(
    .SUM_BINS (SUM_BINS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .cmd           (cmd),
    .sts           (sts),
    .in_value      (in_ch.value),
    .out_bin_index (out_ch.bin_index),
    .out_bin_sum   (out_ch.bin_sum)
  );

  assign out_ch.last_bin = sts.last_bin;

endmodule
